// File: rtl/core/otsu_pkg.sv
`default_nettype none
package otsu_pkg;
    localparam int PIX_W     = 8;
    localparam int THR_W     = 8;
    localparam int COUNT_W   = 21;
    localparam int BINS_DEF  = 256;
endpackage
`default_nettype wire

// File: rtl/core/otsu_threshold_finder.sv
`default_nettype none
// Otsu threshold finder. Pixels are words taken when start is high and
// busy is low; each word adds one count to its bin of a BINS-bin histogram
// (bins saturate at 2^21-1, levels past the last bin count in the last bin).
// Each pixel word is a read-modify-write of the histogram RAM.
// On a word with last_pixel set, the block sweeps thresholds 0..BINS-2
// (ending early once the upper class is empty) and compares between-class
// variances exactly through one shared shift-add multiplier: each
// qualifying threshold costs six products with a DW-bit multiplier operand
// (DW = 2*21+3*log2(BINS), 66 at BINS=256); a threshold with an empty
// lower class is skipped with no products. The result appears
// on threshold for exactly one cycle with valid high; the receiver cannot
// stall it. After each result, and after reset, the histogram is cleared
// by a pass over all BINS bins with busy high.
module otsu_threshold_finder #(
    parameter int BINS = otsu_pkg::BINS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [otsu_pkg::PIX_W-1:0]  pixel,
    input  wire logic                        last_pixel,
    output logic                             valid,
    output logic [otsu_pkg::THR_W-1:0]       threshold
);
    import otsu_pkg::*;

    localparam int LW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CW = COUNT_W;
    localparam int NW = CW + LW;          // pixel counts
    localparam int SW = CW + 2 * LW;      // level sums
    localparam int DW = SW + NW;          // cross products
    localparam int AW = 2 * DW;           // multiplicand
    localparam int BW = DW;               // multiplier
    localparam int PW = AW + BW;          // full product
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
    localparam logic [LW-1:0] BIN_LAST  = LW'(BINS - 1);
    localparam logic [LW-1:0] T_LAST    = LW'(BINS - 2);

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_PIX_WR  = 14'b00000000000100,
        S_SUM_RD  = 14'b00000000001000,
        S_SUM_ACC = 14'b00000000010000,
        S_SUM_UPD = 14'b00000000100000,
        S_CHECK   = 14'b00000001000000,
        S_MUL_X   = 14'b00000010000000,
        S_MUL_Y   = 14'b00000100000000,
        S_MUL_D2  = 14'b00001000000000,
        S_MUL_P   = 14'b00010000000000,
        S_MUL_L   = 14'b00100000000000,
        S_MUL_R   = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [LW-1:0]   clr_reg, clr_next;
    logic [LW-1:0]   t_reg, t_next;
    logic [LW-1:0]   level_reg, level_next;
    logic            last_reg, last_next;
    logic            launched_reg, launched_next;
    logic [NW-1:0]   n_all_reg, n_all_next;
    logic [SW-1:0]   s_all_reg, s_all_next;
    logic [NW-1:0]   n_lo_reg, n_lo_next;
    logic [SW-1:0]   s_lo_reg, s_lo_next;
    logic [LW+CW-1:0] tc_reg, tc_next;
    logic [DW-1:0]   x_reg, x_next;
    logic [DW-1:0]   y_reg, y_next;
    logic [AW-1:0]   d2_reg, d2_next;
    logic [2*NW-1:0] p_reg, p_next;
    logic [PW-1:0]   lhs_reg, lhs_next;
    logic [AW-1:0]   best_d2_reg, best_d2_next;
    logic [2*NW-1:0] best_p_reg, best_p_next;
    logic [LW-1:0]   best_t_reg, best_t_next;

    logic [LW-1:0]   level_in;
    logic [NW-1:0]   n_hi;
    logic [SW-1:0]   s_hi;
    logic [DW-1:0]   d;
    logic            in_mul;
    logic            mul_start, mul_done;
    logic [AW-1:0]   mul_a;
    logic [BW-1:0]   mul_b;
    logic [PW-1:0]   mul_p;
    logic            wr_en;
    logic [LW-1:0]   wr_addr, rd_addr;
    logic [CW-1:0]   wr_data, rd_data;

    // clamp levels beyond the histogram into the last bin
    always_comb
    begin
        if (32'(pixel) >= BINS)
        begin
            level_in = BIN_LAST;
        end
        else
        begin
            level_in = LW'(pixel);
        end
    end

    assign n_hi = n_all_reg - n_lo_reg;
    assign s_hi = s_all_reg - s_lo_reg;
    assign d    = (x_reg >= y_reg) ? (x_reg - y_reg) : (y_reg - x_reg);

    assign in_mul = state_reg inside {S_MUL_X, S_MUL_Y, S_MUL_D2,
                                      S_MUL_P, S_MUL_L, S_MUL_R};
    assign mul_start = in_mul && !launched_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MUL_X:
            begin
                mul_a = AW'(s_lo_reg);
                mul_b = BW'(n_hi);
            end
            S_MUL_Y:
            begin
                mul_a = AW'(s_hi);
                mul_b = BW'(n_lo_reg);
            end
            S_MUL_D2:
            begin
                mul_a = AW'(d);
                mul_b = d;
            end
            S_MUL_P:
            begin
                mul_a = AW'(n_lo_reg);
                mul_b = BW'(n_hi);
            end
            S_MUL_L:
            begin
                mul_a = d2_reg;
                mul_b = BW'(best_p_reg);
            end
            S_MUL_R:
            begin
                mul_a = best_d2_reg;
                mul_b = BW'(p_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    otsu_mul #(.AW(AW), .BW(BW)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // histogram port control
    assign rd_addr = (state_reg == S_IDLE) ? level_in : t_reg;
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = level_reg;
        wr_data = rd_data + 1'b1;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_PIX_WR)
        begin
            wr_en = (rd_data != COUNT_MAX);
        end
    end

    otsu_ram #(.WIDTH(CW), .DEPTH(BINS)) u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        t_next        = t_reg;
        level_next    = level_reg;
        last_next     = last_reg;
        launched_next = launched_reg;
        n_all_next    = n_all_reg;
        s_all_next    = s_all_reg;
        n_lo_next     = n_lo_reg;
        s_lo_next     = s_lo_reg;
        tc_next       = tc_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        d2_next       = d2_reg;
        p_next        = p_reg;
        lhs_next      = lhs_reg;
        best_d2_next  = best_d2_reg;
        best_p_next   = best_p_reg;
        best_t_next   = best_t_reg;
        if (mul_start)
        begin
            launched_next = 1'b1;
        end
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BIN_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    level_next = level_in;
                    last_next  = last_pixel;
                    state_next = S_PIX_WR;
                end
            end
            S_PIX_WR:
            begin
                if (rd_data != COUNT_MAX)
                begin
                    n_all_next = n_all_reg + 1'b1;
                    s_all_next = s_all_reg + SW'(level_reg);
                end
                if (last_reg)
                begin
                    t_next       = '0;
                    n_lo_next    = '0;
                    s_lo_next    = '0;
                    best_d2_next = '0;
                    best_p_next  = (2*NW)'(1);
                    best_t_next  = '0;
                    state_next   = S_SUM_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                n_lo_next  = n_lo_reg + NW'(rd_data);
                tc_next    = {{CW{1'b0}}, t_reg} * {{LW{1'b0}}, rd_data};
                state_next = S_SUM_UPD;
            end
            S_SUM_UPD:
            begin
                s_lo_next  = s_lo_reg + SW'(tc_reg);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (n_lo_reg == '0)
                begin
                    if (t_reg == T_LAST)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        t_next     = t_reg + 1'b1;
                        state_next = S_SUM_RD;
                    end
                end
                else if (n_hi == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL_X;
                end
            end
            S_MUL_X:
            begin
                if (mul_done)
                begin
                    x_next        = mul_p[DW-1:0];
                    launched_next = 1'b0;
                    state_next    = S_MUL_Y;
                end
            end
            S_MUL_Y:
            begin
                if (mul_done)
                begin
                    y_next        = mul_p[DW-1:0];
                    launched_next = 1'b0;
                    state_next    = S_MUL_D2;
                end
            end
            S_MUL_D2:
            begin
                if (mul_done)
                begin
                    d2_next       = mul_p[AW-1:0];
                    launched_next = 1'b0;
                    state_next    = S_MUL_P;
                end
            end
            S_MUL_P:
            begin
                if (mul_done)
                begin
                    p_next        = mul_p[2*NW-1:0];
                    launched_next = 1'b0;
                    state_next    = S_MUL_L;
                end
            end
            S_MUL_L:
            begin
                if (mul_done)
                begin
                    lhs_next      = mul_p;
                    launched_next = 1'b0;
                    state_next    = S_MUL_R;
                end
            end
            S_MUL_R:
            begin
                if (mul_done)
                begin
                    launched_next = 1'b0;
                    // strictly larger only: earliest threshold wins ties
                    if (lhs_reg > mul_p)
                    begin
                        best_d2_next = d2_reg;
                        best_p_next  = p_reg;
                        best_t_next  = t_reg;
                    end
                    if (t_reg == T_LAST)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        t_next     = t_reg + 1'b1;
                        state_next = S_SUM_RD;
                    end
                end
            end
            S_DONE:
            begin
                n_all_next = '0;
                s_all_next = '0;
                clr_next   = '0;
                state_next = S_CLEAR;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            launched_reg <= 1'b0;
            n_all_reg    <= '0;
            s_all_reg    <= '0;
            last_reg     <= 1'b0;
            t_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            launched_reg <= launched_next;
            n_all_reg    <= n_all_next;
            s_all_reg    <= s_all_next;
            last_reg     <= last_next;
            t_reg        <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg   <= level_next;
        n_lo_reg    <= n_lo_next;
        s_lo_reg    <= s_lo_next;
        tc_reg      <= tc_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        d2_reg      <= d2_next;
        p_reg       <= p_next;
        lhs_reg     <= lhs_next;
        best_d2_reg <= best_d2_next;
        best_p_reg  <= best_p_next;
        best_t_reg  <= best_t_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign valid     = (state_reg == S_DONE);
    assign threshold = THR_W'(best_t_reg);

    // result strobe lasts one cycle and is followed by the clearing pass
    a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> (!valid && busy))
        else $error("result strobe longer than one cycle");

    // the multiplier only finishes a product that the sequencer launched
    a_mul_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (launched_reg && in_mul))
        else $error("unexpected multiplier completion");

    // the chosen threshold never lies past the last split
    a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (best_t_reg <= T_LAST))
        else $error("threshold out of range");
endmodule
`default_nettype wire

// File: rtl/core/otsu_ram.sv
`default_nettype none
module otsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: rtl/core/otsu_mul.sv
`default_nettype none
// shift-add multiplier, one multiplier bit per cycle
module otsu_mul #(
    parameter int AW = 8,
    parameter int BW = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [AW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic                  done,
    output logic [AW+BW-1:0]      product
);
    localparam int CNT_W = $clog2(BW + 1);

    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW-1:0]    a_reg, a_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [AW:0]      sum;

    always_comb
    begin
        sum       = {1'b0, acc_reg[AW+BW-1:BW]} + (acc_reg[0] ? {1'b0, a_reg} : '0);
        acc_next  = acc_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = {{AW{1'b0}}, b};
            a_next    = a;
            cnt_next  = CNT_W'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {sum, acc_reg[BW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire
